// ===== src/gpd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpd_pkg
// shared types and constants of the gamepad packet deframer
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int unsigned PayloadLen = 7;
  localparam int unsigned PosW       = 4;
  localparam int unsigned CfgW       = 16;

  localparam logic [PosW-1:0] PosHunt  = 4'd0;
  localparam logic [PosW-1:0] PosCheck = 4'd8;

  localparam logic [7:0] StickCenter = 8'd128;

  localparam logic [7:0]  HeaderRst    = 8'hAA;
  localparam logic [15:0] TimeoutRst   = 16'd500;
  localparam logic [6:0]  DeadbandRst  = 7'd20;
  localparam logic [7:0]  ThresholdRst = 8'd10;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } gpd_op_e;

  typedef enum logic [1:0] {
    CFG_HEADER    = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_DEADBAND  = 2'd2,
    CFG_THRESHOLD = 2'd3
  } gpd_cfg_e;

  typedef enum logic [1:0] {
    FRAME_NONE  = 2'd0,
    FRAME_GOOD  = 2'd1,
    FRAME_ERROR = 2'd2
  } gpd_frame_e;

  // payload order: lx, ly, rx, ry, lt, rt, buttons
  typedef logic [PayloadLen-1:0][7:0] gpd_bytes_t;

  typedef struct packed {
    logic [6:0] deadband;
    logic [7:0] threshold;
  } gpd_act_cfg_t;

  typedef struct packed {
    gpd_bytes_t  values;
    logic [1:0]  frame_status;
    logic        connected;
    logic        input_active;
    logic [15:0] error_total;
    logic [31:0] packet_age;
  } gpd_result_t;

endpackage

// ===== src/gpd_in_if.sv =====
// ----------------------------------------------------------------------------
// gpd_in_if
// input item channel: received byte or millisecond tick
// ----------------------------------------------------------------------------
interface gpd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== src/gpd_out_if.sv =====
// ----------------------------------------------------------------------------
// gpd_out_if
// result item channel: decoded values and link status
// ----------------------------------------------------------------------------
interface gpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_stick_x;
  logic [7:0]  left_stick_y;
  logic [7:0]  right_stick_x;
  logic [7:0]  right_stick_y;
  logic [7:0]  left_trigger;
  logic [7:0]  right_trigger;
  logic [7:0]  button_bits;
  logic [1:0]  frame_status;
  logic        connected;
  logic        input_active;
  logic [15:0] error_total;
  logic [31:0] packet_age;

  modport source (
    output valid, output left_stick_x, output left_stick_y, output right_stick_x,
    output right_stick_y, output left_trigger, output right_trigger,
    output button_bits, output frame_status, output connected, output input_active,
    output error_total, output packet_age, input ready
  );
  modport sink (
    input valid, input left_stick_x, input left_stick_y, input right_stick_x,
    input right_stick_y, input left_trigger, input right_trigger,
    input button_bits, input frame_status, input connected, input input_active,
    input error_total, input packet_age, output ready
  );
endinterface

// ===== src/gpd_activity.sv =====
// ----------------------------------------------------------------------------
// gpd_activity
// flags sticks outside the deadband, triggers over threshold, any button
// ----------------------------------------------------------------------------
module gpd_activity import gpd_pkg::*; (
  input  gpd_bytes_t   values_i,
  input  gpd_act_cfg_t cfg_i,
  output logic         active_o
);

  logic [3:0] stick_off;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [7:0] delta;
      delta = (values_i[i] >= StickCenter) ? (values_i[i] - StickCenter)
                                           : (StickCenter - values_i[i]);
      stick_off[i] = delta > {1'b0, cfg_i.deadband};
    end
  end

  assign active_o = (|stick_off)
                  || (values_i[4] > cfg_i.threshold)
                  || (values_i[5] > cfg_i.threshold)
                  || (values_i[6] != 8'd0);

endmodule

// ===== src/gamepad_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// gamepad_packet_deframer
// header / xor checksum deframer for nine-byte gamepad packets
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ---------------------------------------------
//  in_i     in   valid / ready  operation (byte or tick), rx_byte
//  out_o    out  valid / ready  seven decoded bytes, frame status, connected,
//                               input active, error total, packet age
//  cfg      in   cfg_we_i       cfg_index_i selects register, cfg_data_i value
//
//  one item per clock while results drain: an accepted item updates the
//  deframer state and its result lands in the output register on the same edge
//  in_i.ready is high while the output register is empty or being drained,
//  so a stalled result holds back only the next item
//  reset clears all control state and restores the configuration defaults;
//  the payload store has no reset, every entry is written before a copy
//
module gamepad_packet_deframer import gpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  gpd_in_if.sink          in_i,
  gpd_out_if.source       out_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // configuration registers
  logic [7:0]  header_q;
  logic [15:0] timeout_q;
  logic [6:0]  deadband_q;
  logic [7:0]  threshold_q;

  // deframer state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      store_q [PayloadLen];
  gpd_bytes_t      decoded_q, decoded_d;
  logic [15:0]     err_q, err_d;
  logic            seen_q, seen_d;
  logic [31:0]     age_q, age_d;

  // output register
  logic        out_valid_q;
  gpd_result_t out_q, out_d;

  logic       in_ready;
  logic       in_acc;
  logic       store_we;
  logic [2:0] store_idx;
  logic [1:0] status;
  gpd_bytes_t store_bytes;
  gpd_act_cfg_t act_cfg;
  logic       active;

  // output register can take a new item when empty or being drained
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // position 1..7 writes payload entry position-1
  assign store_idx = pos_q[2:0] - 3'd1;

  always_comb begin
    for (int i = 0; i < PayloadLen; i++) begin
      store_bytes[i] = store_q[i];
    end
  end

  // next-state logic of the deframer
  always_comb begin
    pos_d     = pos_q;
    xor_d     = xor_q;
    decoded_d = decoded_q;
    err_d     = err_q;
    seen_d    = seen_q;
    age_d     = age_q;
    store_we  = 1'b0;
    status    = FRAME_NONE;
    if (in_acc) begin
      priority if (gpd_op_e'(in_i.operation) == OP_TICK) begin
        // tick leaves the deframer alone, age saturates
        if (age_q != 32'hFFFF_FFFF) begin
          age_d = age_q + 32'd1;
        end
      end else if (pos_q == PosHunt) begin
        // hunting: drop everything but the header
        if (in_i.rx_byte == header_q) begin
          pos_d = 4'd1;
          xor_d = 8'd0;
        end
      end else if (pos_q < PosCheck) begin
        // payload byte, header value inside a packet is plain data
        store_we = 1'b1;
        xor_d    = xor_q ^ in_i.rx_byte;
        pos_d    = pos_q + 4'd1;
      end else begin
        // checksum byte closes the frame either way
        if (xor_q == in_i.rx_byte) begin
          decoded_d = store_bytes;
          age_d     = 32'd0;
          seen_d    = 1'b1;
          status    = FRAME_GOOD;
        end else begin
          err_d  = err_q + 16'd1;
          status = FRAME_ERROR;
        end
        pos_d = PosHunt;
        xor_d = 8'd0;
      end
    end
  end

  assign act_cfg.deadband  = deadband_q;
  assign act_cfg.threshold = threshold_q;

  // activity seen on the values this item leaves behind
  gpd_activity u_activity (
    .values_i (decoded_d),
    .cfg_i    (act_cfg),
    .active_o (active)
  );

  always_comb begin
    out_d.values       = decoded_d;
    out_d.frame_status = status;
    out_d.connected    = seen_d && (age_d < {16'd0, timeout_q});
    out_d.input_active = active;
    out_d.error_total  = err_d;
    out_d.packet_age   = age_d;
  end

  // control state, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= HeaderRst;
      timeout_q   <= TimeoutRst;
      deadband_q  <= DeadbandRst;
      threshold_q <= ThresholdRst;
      pos_q       <= PosHunt;
      xor_q       <= 8'd0;
      decoded_q   <= {8'd0, 8'd0, 8'd0, StickCenter, StickCenter, StickCenter, StickCenter};
      err_q       <= 16'd0;
      seen_q      <= 1'b0;
      age_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (gpd_cfg_e'(cfg_index_i))
          CFG_HEADER:    header_q    <= cfg_data_i[7:0];
          CFG_TIMEOUT:   timeout_q   <= cfg_data_i[15:0];
          CFG_DEADBAND:  deadband_q  <= cfg_data_i[6:0];
          CFG_THRESHOLD: threshold_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      decoded_q <= decoded_d;
      err_q     <= err_d;
      seen_q    <= seen_d;
      age_q     <= age_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload store and result data, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= in_i.rx_byte;
    end
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_stick_x  = out_q.values[0];
  assign out_o.left_stick_y  = out_q.values[1];
  assign out_o.right_stick_x = out_q.values[2];
  assign out_o.right_stick_y = out_q.values[3];
  assign out_o.left_trigger  = out_q.values[4];
  assign out_o.right_trigger = out_q.values[5];
  assign out_o.button_bits   = out_q.values[6];
  assign out_o.frame_status  = out_q.frame_status;
  assign out_o.connected     = out_q.connected;
  assign out_o.input_active  = out_q.input_active;
  assign out_o.error_total   = out_q.error_total;
  assign out_o.packet_age    = out_q.packet_age;

  // position never runs past the checksum slot
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosCheck)
    else $error("byte position out of range");

  // a good frame always restarts the age
  a_good_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.frame_status == FRAME_GOOD) |-> (out_q.packet_age == 32'd0))
    else $error("good frame with nonzero age");

  // no link before the first good packet
  a_no_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !seen_q |-> !out_q.connected)
    else $error("connected before any good packet");

  // ticks do not move the deframer
  a_tick_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (gpd_op_e'(in_i.operation) == OP_TICK) |=> pos_q == $past(pos_q))
    else $error("tick changed byte position");

  // a checksum byte always ends a frame
  a_check_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (gpd_op_e'(in_i.operation) == OP_BYTE) && (pos_q == PosCheck)
    |=> out_valid_q && (out_q.frame_status != FRAME_NONE) && (pos_q == PosHunt))
    else $error("checksum byte did not close frame");

endmodule
